// ===== rtl/core/kvce_pkg.sv =====
// ----------------------------------------------------------------------------
// kvce_pkg
// Shared types and constants of the key-value command engine.
// ----------------------------------------------------------------------------
package kvce_pkg;

    localparam int TableEntries = 1024;
    localparam int StringBytes  = 50;

    localparam int SlotW  = $clog2(TableEntries);
    localparam int CountW = $clog2(TableEntries + 1);
    localparam int PosW   = $clog2(StringBytes);
    localparam int AddrW  = $clog2(TableEntries * StringBytes);

    localparam logic [7:0] ChPut  = 8'h70;
    localparam logic [7:0] ChGet  = 8'h67;
    localparam logic [7:0] ChNone = 8'h6e;
    localparam logic [7:0] ChFnd  = 8'h66;
    localparam logic [7:0] ChNul  = 8'h00;
    localparam logic [PosW-1:0] MaxLen = PosW'(StringBytes - 1);

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic               buf_key_wr;   // write key buffer at pos
        logic               buf_val_wr;   // write value buffer at pos
        logic [PosW-1:0]    buf_pos;
        logic [7:0]         buf_data;
        logic [SlotW-1:0]   slot;
        logic [PosW-1:0]    pos;
        logic               key_wr;       // write key store from key buffer
        logic               val_wr;       // write value store from value buffer
        logic               key_nul;      // write NUL into the key store
        logic               val_nul;      // write NUL into the value store
    } kvce_cmd_t;

    // Datapath status back to the controller (registered read data).
    typedef struct packed {
        logic [7:0] store_byte;
        logic [7:0] buf_byte;
        logic [7:0] val_byte;
    } kvce_stat_t;

endpackage

// ===== rtl/core/kvce_datapath.sv =====
// ----------------------------------------------------------------------------
// kvce_datapath
// String buffers and the key/value table memories.
// ----------------------------------------------------------------------------
module kvce_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kvce_pkg::kvce_cmd_t  cmd,
    output kvce_pkg::kvce_stat_t stat
);

    logic [7:0] key_buf [kvce_pkg::StringBytes];
    logic [7:0] val_buf [kvce_pkg::StringBytes];
    logic [7:0] key_mem [kvce_pkg::TableEntries * kvce_pkg::StringBytes];
    logic [7:0] val_mem [kvce_pkg::TableEntries * kvce_pkg::StringBytes];
    logic [kvce_pkg::AddrW-1:0] addr;
    logic [kvce_pkg::AddrW-1:0] wr_addr_reg;
    logic                       key_wr_reg;
    logic                       val_wr_reg;
    logic                       key_nul_reg;
    logic                       val_nul_reg;
    logic [7:0]                 kbuf_byte_reg;
    logic [7:0]                 vbuf_byte_reg;
    logic [7:0]                 store_byte_reg;
    logic [7:0]                 val_byte_reg;
    logic [7:0]                 key_src;
    logic [7:0]                 val_src;

    // Form the flat table address of slot and position
    assign addr = kvce_pkg::AddrW'(cmd.slot) * kvce_pkg::AddrW'(kvce_pkg::StringBytes)
                + kvce_pkg::AddrW'(cmd.pos);

    // Write the string buffers
    always_ff @(posedge clk)
    begin
        if (cmd.buf_key_wr)
        begin
            key_buf[cmd.buf_pos] <= cmd.buf_data;
        end
        if (cmd.buf_val_wr)
        begin
            val_buf[cmd.buf_pos] <= cmd.buf_data;
        end
    end

    // Read buffers for compare and copy
    always_ff @(posedge clk)
    begin
        kbuf_byte_reg <= key_buf[cmd.pos];
        vbuf_byte_reg <= val_buf[cmd.pos];
    end

    // Register table writes so that they line up with buffer read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_addr_reg <= '0;
            key_wr_reg  <= 1'b0;
            val_wr_reg  <= 1'b0;
            key_nul_reg <= 1'b0;
            val_nul_reg <= 1'b0;
        end
        else
        begin
            wr_addr_reg <= addr;
            key_wr_reg  <= cmd.key_wr;
            val_wr_reg  <= cmd.val_wr;
            key_nul_reg <= cmd.key_nul;
            val_nul_reg <= cmd.val_nul;
        end
    end

    assign key_src = key_nul_reg ? kvce_pkg::ChNul : kbuf_byte_reg;
    assign val_src = val_nul_reg ? kvce_pkg::ChNul : vbuf_byte_reg;

    // Key store port
    always_ff @(posedge clk)
    begin
        if (key_wr_reg)
        begin
            key_mem[wr_addr_reg] <= key_src;
        end
        store_byte_reg <= key_mem[addr];
    end

    // Value store port
    always_ff @(posedge clk)
    begin
        if (val_wr_reg)
        begin
            val_mem[wr_addr_reg] <= val_src;
        end
        val_byte_reg <= val_mem[addr];
    end

    assign stat = '{store_byte: store_byte_reg, buf_byte: kbuf_byte_reg,
                    val_byte: val_byte_reg};

endmodule

// ===== rtl/core/kvce_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvce_ctrl
// Command parser, linear key search and reply sequencer.
// ----------------------------------------------------------------------------
module kvce_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           reply_byte,
    output logic                 last_of_reply,
    output logic                 close_request,
    output kvce_pkg::kvce_cmd_t  cmd,
    input  kvce_pkg::kvce_stat_t stat
);

    typedef enum logic [3:0] {
        S_CMD, S_PKEY, S_PVAL, S_GKEY, S_DISC,
        S_SRCH, S_SCMP, S_COPY, S_RREQ, S_RDAT, S_OUT
    } state_t;

    state_t                         state_reg;
    logic                           is_get_reg;
    logic                           found_reg;
    logic                           match_reg;
    logic [kvce_pkg::PosW-1:0]      klen_reg;
    logic [kvce_pkg::PosW-1:0]      vlen_reg;
    logic [kvce_pkg::PosW-1:0]      pos_reg;
    logic [kvce_pkg::SlotW-1:0]     slot_reg;
    logic [kvce_pkg::CountW-1:0]    count_reg;
    logic                           ovalid_reg;
    logic [7:0]                     obyte_reg;
    logic                           olast_reg;
    logic                           oclose_reg;
    logic                           take;
    logic                           oready;
    logic                           slot_end;

    assign oready   = !ovalid_reg || !out_stall;
    assign in_stall = !(state_reg == S_CMD || state_reg == S_PKEY ||
                        state_reg == S_PVAL || state_reg == S_GKEY ||
                        state_reg == S_DISC) || !oready;
    assign take     = in_valid && !in_stall;
    assign slot_end = {1'b0, slot_reg} + 1'b1 >= count_reg;

    assign out_valid     = ovalid_reg;
    assign reply_byte    = obyte_reg;
    assign last_of_reply = olast_reg;
    assign close_request = oclose_reg;

    // Drive memory commands
    always_comb
    begin
        cmd            = '0;
        cmd.buf_data   = data_byte;
        cmd.buf_pos    = (state_reg == S_PVAL) ? vlen_reg : klen_reg;
        cmd.slot       = slot_reg;
        cmd.pos        = pos_reg;
        if (take && !kind && data_byte != kvce_pkg::ChNul)
        begin
            cmd.buf_key_wr = (state_reg == S_PKEY || state_reg == S_GKEY)
                             && klen_reg < kvce_pkg::MaxLen;
            cmd.buf_val_wr = state_reg == S_PVAL && vlen_reg < kvce_pkg::MaxLen;
        end
        if (state_reg == S_COPY)
        begin
            cmd.val_wr  = pos_reg <= vlen_reg;
            cmd.key_wr  = !found_reg && pos_reg <= klen_reg;
            cmd.val_nul = pos_reg == vlen_reg;
            cmd.key_nul = pos_reg == klen_reg;
        end
    end

    // Hold state, counters and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CMD;
            is_get_reg <= 1'b0;
            found_reg  <= 1'b0;
            match_reg  <= 1'b0;
            klen_reg   <= '0;
            vlen_reg   <= '0;
            pos_reg    <= '0;
            slot_reg   <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            obyte_reg  <= '0;
            olast_reg  <= 1'b0;
            oclose_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            if (take && kind)
            begin
                state_reg <= S_CMD;
                klen_reg  <= '0;
                vlen_reg  <= '0;
            end
            else if (take)
            begin
                unique case (state_reg)
                    S_CMD:
                    begin
                        klen_reg <= '0;
                        if (data_byte == kvce_pkg::ChPut)
                        begin
                            state_reg  <= S_PKEY;
                            is_get_reg <= 1'b0;
                        end
                        else if (data_byte == kvce_pkg::ChGet)
                        begin
                            state_reg  <= S_GKEY;
                            is_get_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg  <= S_DISC;
                            ovalid_reg <= 1'b1;
                            obyte_reg  <= kvce_pkg::ChNul;
                            olast_reg  <= 1'b1;
                            oclose_reg <= 1'b1;
                        end
                    end
                    S_PKEY, S_GKEY:
                    begin
                        if (data_byte != kvce_pkg::ChNul)
                        begin
                            if (klen_reg < kvce_pkg::MaxLen)
                            begin
                                klen_reg <= klen_reg + 1'b1;
                            end
                        end
                        else if (klen_reg == '0)
                        begin
                            state_reg  <= S_DISC;
                            ovalid_reg <= 1'b1;
                            obyte_reg  <= kvce_pkg::ChNul;
                            olast_reg  <= 1'b1;
                            oclose_reg <= 1'b1;
                        end
                        else if (state_reg == S_PKEY)
                        begin
                            state_reg <= S_PVAL;
                            vlen_reg  <= '0;
                        end
                        else
                        begin
                            state_reg <= S_SRCH;
                            slot_reg  <= '0;
                            pos_reg   <= '0;
                            found_reg <= 1'b0;
                        end
                    end
                    S_PVAL:
                    begin
                        if (data_byte != kvce_pkg::ChNul)
                        begin
                            if (vlen_reg < kvce_pkg::MaxLen)
                            begin
                                vlen_reg <= vlen_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            state_reg <= S_SRCH;
                            slot_reg  <= '0;
                            pos_reg   <= '0;
                            found_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                        state_reg <= state_reg;
                    end
                endcase
            end
            else
            begin
                unique case (state_reg)
                    // Start a compare of one slot, or finish the search
                    S_SRCH:
                    begin
                        if ({1'b0, slot_reg} >= count_reg)
                        begin
                            found_reg <= 1'b0;
                            pos_reg   <= '0;
                            if (is_get_reg)
                            begin
                                state_reg <= S_RREQ;
                            end
                            else if (count_reg < kvce_pkg::CountW'(kvce_pkg::TableEntries))
                            begin
                                state_reg <= S_COPY;
                            end
                            else
                            begin
                                state_reg <= S_CMD;
                                klen_reg  <= '0;
                                vlen_reg  <= '0;
                            end
                        end
                        else
                        begin
                            state_reg <= S_SCMP;
                            pos_reg   <= pos_reg + 1'b1;
                            match_reg <= 1'b1;
                        end
                    end
                    // Compare one byte a cycle against the key buffer
                    S_SCMP:
                    begin
                        if ((pos_reg - 1'b1) == klen_reg)
                        begin
                            if (match_reg && stat.store_byte == kvce_pkg::ChNul)
                            begin
                                found_reg <= 1'b1;
                                pos_reg   <= '0;
                                state_reg <= is_get_reg ? S_RREQ : S_COPY;
                            end
                            else if (slot_end)
                            begin
                                // No stored key matched: miss, append or drop
                                found_reg <= 1'b0;
                                pos_reg   <= '0;
                                slot_reg  <= kvce_pkg::SlotW'(count_reg);
                                if (is_get_reg)
                                begin
                                    state_reg <= S_RREQ;
                                end
                                else if (count_reg < kvce_pkg::CountW'(kvce_pkg::TableEntries))
                                begin
                                    state_reg <= S_COPY;
                                end
                                else
                                begin
                                    state_reg <= S_CMD;
                                    klen_reg  <= '0;
                                    vlen_reg  <= '0;
                                end
                            end
                            else
                            begin
                                slot_reg  <= slot_reg + 1'b1;
                                pos_reg   <= '0;
                                state_reg <= S_SRCH;
                            end
                        end
                        else
                        begin
                            if (stat.store_byte != stat.buf_byte)
                            begin
                                match_reg <= 1'b0;
                            end
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                    // Write value, and key for a new entry
                    S_COPY:
                    begin
                        if (pos_reg >= vlen_reg && (found_reg || pos_reg >= klen_reg))
                        begin
                            if (!found_reg)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= S_CMD;
                            klen_reg  <= '0;
                            vlen_reg  <= '0;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                    // Emit the first reply byte
                    S_RREQ:
                    begin
                        if (oready)
                        begin
                            ovalid_reg <= 1'b1;
                            oclose_reg <= 1'b0;
                            if (found_reg)
                            begin
                                obyte_reg <= kvce_pkg::ChFnd;
                                olast_reg <= 1'b0;
                                state_reg <= S_RDAT;
                            end
                            else
                            begin
                                obyte_reg <= kvce_pkg::ChNone;
                                olast_reg <= 1'b1;
                                state_reg <= S_CMD;
                                klen_reg  <= '0;
                            end
                        end
                    end
                    // Wait for value read data
                    S_RDAT:
                    begin
                        state_reg <= S_OUT;
                    end
                    S_OUT:
                    begin
                        if (oready)
                        begin
                            ovalid_reg <= 1'b1;
                            oclose_reg <= 1'b0;
                            if (stat.val_byte == kvce_pkg::ChNul || pos_reg == kvce_pkg::MaxLen)
                            begin
                                obyte_reg <= kvce_pkg::ChNul;
                                olast_reg <= 1'b1;
                                state_reg <= S_CMD;
                                klen_reg  <= '0;
                            end
                            else
                            begin
                                obyte_reg <= stat.val_byte;
                                olast_reg <= 1'b0;
                                pos_reg   <= pos_reg + 1'b1;
                                state_reg <= S_RDAT;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= state_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/key_value_command_engine.sv =====
// Put and get terminators stall input while the search runs, which reads each
// stored entry through the single key-store read port, and while the entry is
// written or the reply is sent.
// Throughput: one ordinary byte per cycle while the reply side is not stalled. Reset: asynchronous, clears the parser
// and entry count; table memories are not cleared.
// ----------------------------------------------------------------------------
// key_value_command_engine
// Put/get command engine over a linearly searched key/value table.
// ----------------------------------------------------------------------------
module key_value_command_engine
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] reply_byte,
    output logic       last_of_reply,
    output logic       close_request
);

    kvce_pkg::kvce_cmd_t  cmd;
    kvce_pkg::kvce_stat_t stat;

    kvce_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reply_byte    (reply_byte),
        .last_of_reply (last_of_reply),
        .close_request (close_request),
        .cmd           (cmd),
        .stat          (stat)
    );

    kvce_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ===== dv/key_value_command_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_command_engine_test
// Drives put/get command streams into the engine with random gaps and
// receiver stalls, predicts every reply byte and close, and compares them.
// ----------------------------------------------------------------------------
module key_value_command_engine_test;

    typedef struct {
        logic [7:0] rbyte;
        logic       last;
        logic       cls;
    } reply_t;

    typedef enum int {PhCmd, PhPutKey, PhPutVal, PhGetKey} phase_t;

    localparam int HoldCycles = 400;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       kind;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] reply_byte;
    logic       last_of_reply;
    logic       close_request;

    // predictor state
    byte unsigned table_keys[$][$];
    byte unsigned table_vals[$][$];
    byte unsigned cur_key[$];
    byte unsigned cur_val[$];
    phase_t       phase;
    bit           dropping;
    reply_t       pending_replies[$];

    int  mismatches = 0;
    bit  hold_off;
    bit  hold_go;
    bit  hold_ack;
    bit  long_gaps;
    int  hold_cycles;

    key_value_command_engine dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reply_byte    (reply_byte),
        .last_of_reply (last_of_reply),
        .close_request (close_request)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int find_slot();
        bit same;
        for (int i = 0; i < table_keys.size(); i++)
        begin
            same = (table_keys[i].size() == cur_key.size());
            for (int j = 0; same && j < cur_key.size(); j++)
            begin
                if (table_keys[i][j] != cur_key[j])
                    same = 1'b0;
            end
            if (same)
                return i;
        end
        return -1;
    endfunction

    function automatic void push_reply(logic [7:0] b, logic l, logic c);
        reply_t r;
        r.rbyte = b;
        r.last  = l;
        r.cls   = c;
        pending_replies.push_back(r);
    endfunction

    // Advance the predictor by one accepted request.
    function automatic void predict_request(logic k, logic [7:0] b);
        int slot;
        if (k)
        begin
            phase = PhCmd;
            dropping = 0;
            return;
        end
        if (dropping)
            return;
        case (phase)
            PhCmd:
            begin
                cur_key.delete();
                if (b == kvce_pkg::ChPut)
                    phase = PhPutKey;
                else if (b == kvce_pkg::ChGet)
                    phase = PhGetKey;
                else
                begin
                    dropping = 1;
                    push_reply(kvce_pkg::ChNul, 1'b1, 1'b1);
                end
            end
            PhPutKey, PhGetKey:
            begin
                if (b != kvce_pkg::ChNul)
                begin
                    if (cur_key.size() < kvce_pkg::StringBytes - 1)
                        cur_key.push_back(b);
                end
                else if (cur_key.size() == 0)
                begin
                    phase = PhCmd;
                    dropping = 1;
                    push_reply(kvce_pkg::ChNul, 1'b1, 1'b1);
                end
                else if (phase == PhPutKey)
                begin
                    phase = PhPutVal;
                    cur_val.delete();
                end
                else
                begin
                    slot = find_slot();
                    if (slot < 0)
                        push_reply(kvce_pkg::ChNone, 1'b1, 1'b0);
                    else
                    begin
                        push_reply(kvce_pkg::ChFnd, 1'b0, 1'b0);
                        for (int i = 0; i < table_vals[slot].size(); i++)
                            push_reply(table_vals[slot][i], 1'b0, 1'b0);
                        push_reply(kvce_pkg::ChNul, 1'b1, 1'b0);
                    end
                    phase = PhCmd;
                end
            end
            PhPutVal:
            begin
                if (b != kvce_pkg::ChNul)
                begin
                    if (cur_val.size() < kvce_pkg::StringBytes - 1)
                        cur_val.push_back(b);
                end
                else
                begin
                    slot = find_slot();
                    if (slot >= 0)
                        table_vals[slot] = cur_val;
                    else if (table_keys.size() < kvce_pkg::TableEntries)
                    begin
                        table_keys.push_back(cur_key);
                        table_vals.push_back(cur_val);
                    end
                    phase = PhCmd;
                end
            end
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return long_gaps ? $urandom_range(0, 3) : 0;
    endfunction

    // Send one request and wait for it to be taken.
    task automatic send_request(logic k, logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(k, b);
    endtask

    task automatic send_string(byte unsigned s[$]);
        foreach (s[i])
            send_request(1'b0, s[i]);
        send_request(1'b0, kvce_pkg::ChNul);
    endtask

    function automatic void rand_string(output byte unsigned s[$], input int maxlen,
                                        input int alpha);
        int n;
        s.delete();
        n = $urandom_range(1, maxlen);
        for (int i = 0; i < n; i++)
            s.push_back(alpha ? byte'(8'h61 + $urandom_range(0, 3))
                              : byte'($urandom_range(1, 255)));
    endfunction

    task automatic send_put(byte unsigned key[$], byte unsigned val[$]);
        send_request(1'b0, kvce_pkg::ChPut);
        send_string(key);
        send_string(val);
    endtask

    task automatic send_get(byte unsigned key[$]);
        send_request(1'b0, kvce_pkg::ChGet);
        send_string(key);
    endtask

    task automatic test_directed();
        byte unsigned k[$];
        byte unsigned v[$];
        byte unsigned lk[$];
        byte unsigned sk[$];
        // miss on empty table, then store and fetch
        k = '{8'h61};
        send_get(k);
        v = '{8'hff, 8'h01};
        send_put(k, v);
        send_get(k);
        // empty value, overwrite
        v.delete();
        send_put(k, v);
        send_get(k);
        // overlong key and value are truncated
        lk.delete();
        sk.delete();
        for (int i = 0; i < kvce_pkg::StringBytes; i++)
        begin
            lk.push_back(byte'(8'h80 + i));
            if (i < kvce_pkg::StringBytes - 1)
                sk.push_back(byte'(8'h80 + i));
        end
        send_put(lk, lk);
        send_get(sk);
        // empty key closes, bytes ignored until a new connection
        send_request(1'b0, kvce_pkg::ChGet);
        send_request(1'b0, kvce_pkg::ChNul);
        send_request(1'b0, kvce_pkg::ChPut);
        send_request(1'b1, 8'h00);
        // bad command bytes: NUL and 0xff
        send_request(1'b0, kvce_pkg::ChNul);
        send_request(1'b1, 8'hff);
        send_request(1'b0, 8'hff);
        send_request(1'b1, 8'h00);
        // new connection mid-command drops the partial put
        send_request(1'b0, kvce_pkg::ChPut);
        send_request(1'b0, 8'h7a);
        send_request(1'b1, 8'h00);
        k = '{8'h7a};
        send_get(k);
    endtask

    task automatic test_random(int count);
        byte unsigned k[$];
        byte unsigned v[$];
        int sel;
        for (int n = 0; n < count; )
        begin
            sel = $urandom_range(0, 9);
            rand_string(k, ($urandom_range(0, 9) == 0) ? 55 : 3, $urandom_range(0, 3) != 0);
            if (sel < 4)
            begin
                rand_string(v, ($urandom_range(0, 9) == 0) ? 55 : 4, 0);
                if ($urandom_range(0, 5) == 0)
                    v.delete();
                send_put(k, v);
                n += 3 + k.size() + v.size();
            end
            else if (sel < 8)
            begin
                send_get(k);
                n += 2 + k.size();
            end
            else
            begin
                // noise: random bytes, then a fresh connection
                repeat (3)
                    send_request(1'b0, 8'($urandom_range(0, 255)));
                send_request(1'b1, 8'($urandom_range(0, 255)));
                n += 4;
            end
        end
    endtask

    // Check each reply against the oldest prediction.
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply %h last %b close %b",
                             reply_byte, last_of_reply, close_request);
            end
            else
            begin
                e = pending_replies.pop_front();
                if (reply_byte !== e.rbyte || last_of_reply !== e.last ||
                    close_request !== e.cls)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply exp %h/%b/%b got %h/%b/%b", e.rbyte, e.last,
                                 e.cls, reply_byte, last_of_reply, close_request);
                end
            end
        end
    end

    // Stall the reply side at random, or hold it off while requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if (long_gaps)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    // Long receiver hold-off, counted in cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_off    <= 1'b0;
            hold_ack    <= 1'b0;
        end
        else if (hold_go != hold_ack)
        begin
            hold_ack    <= hold_go;
            hold_cycles <= HoldCycles;
            hold_off    <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            hold_off    <= (hold_cycles > 1);
        end
    end

    initial
    begin
        #20000000;
        $display("key_value_command_engine: mismatch");
        $finish;
    end

    initial
    begin
        byte unsigned k[$];
        byte unsigned v[$];
        int wait_cycles;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = 1'b0;
        data_byte   = 8'h00;
        hold_go     = 1'b0;
        long_gaps   = 1'b0;
        phase       = PhCmd;
        dropping    = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        long_gaps = 1'b1;
        test_random(8);

        // receiver holds off while gets keep coming
        hold_go = 1'b1;
        k = '{8'h61};
        v = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};
        send_put(k, v);
        repeat (3)
            send_get(k);
        long_gaps = 1'b0;
        test_random(8);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_replies.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200)
            @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("key_value_command_engine: match");
        else
            $display("key_value_command_engine: mismatch");
        $finish;
    end
endmodule

// ===== key_value_command_engine.f =====
rtl/core/kvce_pkg.sv
rtl/core/kvce_datapath.sv
rtl/core/kvce_ctrl.sv
rtl/core/key_value_command_engine.sv
dv/key_value_command_engine_test.sv
